/* hdl/qard_pkg.sv */
// ============================================================================
// qard_pkg: shared types and constants of the ACK range decoder
// Field widths, result status codes and the structures that pass between the
// variable-length integer assembler, the range walker and the top level.
// ============================================================================
`default_nettype none

package qard_pkg;

    // Width of a packet number and of a decoded variable-length integer.
    localparam int unsigned PN_W = 62;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ENC   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Input operation codes.
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Control of the integer assembler.
    typedef struct packed {
        logic clear;
        logic step;
    } t_vctl;

    // Output of the integer assembler for the byte being stepped.
    typedef struct packed {
        logic            done;
        logic [PN_W-1:0] value;
    } t_vres;

    // One result item, with a flag that says whether it exists.
    typedef struct packed {
        logic            emit;
        logic [PN_W-1:0] low;
        logic [PN_W-1:0] high;
        logic [1:0]      status;
        logic            last;
    } t_result;

endpackage

`default_nettype wire

/* hdl/qard_varint.sv */
// ============================================================================
// qard_varint: variable-length integer assembler
// Collects big-endian bytes of a 1, 2, 4 or 8 byte integer whose length is
// given by the top two bits of its first byte, and flags the final byte.
// ============================================================================
`default_nettype none

module qard_varint
    import qard_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_vctl      i_ctl,
    input  wire logic [7:0] i_byte,
    output t_vres           o_res
);

    logic [PN_W-1:0] r_accum;
    logic [PN_W-1:0] n_accum;
    logic [2:0]      r_left;
    logic [2:0]      n_left;

    // A byte either opens a new integer or shifts into the running one.
    always_comb begin
        if (r_left == 3'd0) begin
            n_accum = {{(PN_W-6){1'b0}}, i_byte[5:0]};
            unique case (i_byte[7:6])
                2'd0:    n_left = 3'd0;
                2'd1:    n_left = 3'd1;
                2'd2:    n_left = 3'd3;
                default: n_left = 3'd7;
            endcase
        end else begin
            n_accum = {r_accum[PN_W-9:0], i_byte};
            n_left  = r_left - 3'd1;
        end
    end

    assign o_res.done  = (n_left == 3'd0);
    assign o_res.value = n_accum;

    // Byte count is control state; the accumulator is reloaded on each start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_left <= 3'd0;
        end else if (i_ctl.step) begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_accum <= n_accum;
        end
    end

endmodule

`default_nettype wire

/* hdl/qard_walk.sv */
// ============================================================================
// qard_walk: ACK range walker
// Turns completed integers into ranges: the first range, then pairs of gap
// and length, with underflow and truncation checks, and builds the result.
// ============================================================================
`default_nettype none

module qard_walk
    import qard_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_begin,
    input  wire logic [PN_W-1:0] i_largest,
    input  wire logic [PN_W-1:0] i_range_count,
    input  wire logic            i_byte_step,
    input  wire logic            i_last,
    input  wire t_vres           i_vres,
    output logic                 o_walking,
    output t_result              o_res
);

    typedef enum logic [1:0] {
        K_FIRST,
        K_GAP,
        K_LEN
    } t_kind;

    logic            r_walking;
    logic            n_walking;
    t_kind           r_kind;
    t_kind           n_kind;
    logic [PN_W-1:0] r_cur_low;
    logic [PN_W-1:0] n_cur_low;
    logic [PN_W-1:0] r_cur_high;
    logic [PN_W-1:0] n_cur_high;
    logic [PN_W-1:0] r_pairs;
    logic [PN_W-1:0] n_pairs;
    logic [PN_W-1:0] r_gap_high;
    logic [PN_W-1:0] n_gap_high;
    logic            r_gap_uflow;
    logic            n_gap_uflow;

    logic [PN_W+1:0] gap_diff;
    logic [PN_W-1:0] base_high;
    logic [PN_W-1:0] pairs_after;
    logic [PN_W:0]   len_diff;
    logic            len_uflow;
    logic            range_done;

    // The next high edge after a gap is worked out as soon as the gap is
    // known, so a length needs only one subtract when it completes.
    assign gap_diff    = {2'b00, r_cur_low} - {2'b00, i_vres.value} - (PN_W+2)'(2);
    assign base_high   = (r_kind == K_LEN) ? r_gap_high : r_cur_high;
    assign pairs_after = (r_kind == K_LEN) ? (r_pairs - PN_W'(1)) : r_pairs;
    assign len_diff    = {1'b0, base_high} - {1'b0, i_vres.value};
    assign len_uflow   = len_diff[PN_W] || ((r_kind == K_LEN) && r_gap_uflow);

    assign o_walking = r_walking;

    // Walk step for one byte item.
    always_comb begin
        n_walking   = r_walking;
        n_kind      = r_kind;
        n_cur_low   = r_cur_low;
        n_cur_high  = r_cur_high;
        n_pairs     = r_pairs;
        n_gap_high  = r_gap_high;
        n_gap_uflow = r_gap_uflow;
        range_done  = 1'b0;
        o_res       = '0;

        if (i_byte_step && r_walking) begin
            if (i_vres.done && (r_kind == K_GAP)) begin
                n_gap_high  = gap_diff[PN_W-1:0];
                n_gap_uflow = gap_diff[PN_W+1];
                n_kind      = K_LEN;
            end else if (i_vres.done && len_uflow) begin
                n_walking    = 1'b0;
                o_res.emit   = 1'b1;
                o_res.status = ST_ENC;
                o_res.last   = 1'b1;
            end else if (i_vres.done) begin
                range_done = 1'b1;
                n_cur_high = base_high;
                n_cur_low  = len_diff[PN_W-1:0];
                n_pairs    = pairs_after;
                n_kind     = K_GAP;
            end

            // Emit the range or the truncation, whichever applies.
            if (!(i_vres.done && (r_kind != K_GAP) && len_uflow)) begin
                priority if (range_done && (pairs_after == '0)) begin
                    n_walking    = 1'b0;
                    n_kind       = K_FIRST;
                    o_res.emit   = 1'b1;
                    o_res.low    = n_cur_low;
                    o_res.high   = n_cur_high;
                    o_res.status = ST_OK;
                    o_res.last   = 1'b1;
                end else if (i_last) begin
                    n_walking    = 1'b0;
                    o_res.emit   = 1'b1;
                    o_res.low    = range_done ? n_cur_low : '0;
                    o_res.high   = range_done ? n_cur_high : '0;
                    o_res.status = ST_TRUNC;
                    o_res.last   = 1'b1;
                end else if (range_done) begin
                    o_res.emit   = 1'b1;
                    o_res.low    = n_cur_low;
                    o_res.high   = n_cur_high;
                    o_res.status = ST_OK;
                    o_res.last   = 1'b0;
                end else begin
                    o_res.emit = 1'b0;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking <= 1'b0;
            r_kind    <= K_FIRST;
        end else if (i_begin) begin
            r_walking <= 1'b1;
            r_kind    <= K_FIRST;
        end else begin
            r_walking <= n_walking;
            r_kind    <= n_kind;
        end
    end

    // Range bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_begin) begin
            r_cur_low   <= '0;
            r_cur_high  <= i_largest;
            r_pairs     <= i_range_count;
            r_gap_high  <= '0;
            r_gap_uflow <= 1'b0;
        end else begin
            r_cur_low   <= n_cur_low;
            r_cur_high  <= n_cur_high;
            r_pairs     <= n_pairs;
            r_gap_high  <= n_gap_high;
            r_gap_uflow <= n_gap_uflow;
        end
    end

endmodule

`default_nettype wire

/* hdl/quic_ack_range_decoder.sv */
// ============================================================================
// quic_ack_range_decoder: QUIC ACK range section decoder
// Decodes the range section of an ACK frame one byte per item and emits the
// acknowledged packet number ranges with a status.
// ============================================================================
// Usage:
// The input channel (i_valid, o_ready) carries one item per handshake: a
// begin item (i_op low) with the largest acknowledged number and the pair
// count, or a section byte (i_op high) with a flag on the final byte.
// The output channel (o_valid, i_ready) carries at most one result per
// input item: a range with status valid, encoding error or truncated, and
// a flag on the last result of the section.
// An accepted item sits in the input register; when the result register
// can take a result, the walk logic processes the item and loads the result
// register, which drives o_valid.
// Throughput is one item per cycle unless the receiver stalls; the walker
// updates its state as the item is taken and each byte needs one subtract.
// A stalled receiver holds the result register, and the item in the input
// register then waits as well, whether or not it gives a result; o_ready
// falls while both registers are occupied and the receiver is stalled.
// Reset clears both registers and leaves the walker idle: bytes are
// ignored until a begin item arrives.
// ============================================================================
`default_nettype none

module quic_ack_range_decoder
    import qard_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_op,
    input  wire logic [PN_W-1:0] i_largest,
    input  wire logic [PN_W-1:0] i_range_count,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [PN_W-1:0]      o_range_low,
    output logic [PN_W-1:0]      o_range_high,
    output logic [1:0]           o_status,
    output logic                 o_last_range
);

    logic            r_in_valid;
    logic            r_op;
    logic [PN_W-1:0] r_largest;
    logic [PN_W-1:0] r_range_count;
    logic [7:0]      r_data_byte;
    logic            r_last_byte;
    logic            r_out_valid;
    logic [PN_W-1:0] r_range_low;
    logic [PN_W-1:0] r_range_high;
    logic [1:0]      r_status;
    logic            r_last_range;

    logic    take_item;
    logic    walking;
    logic    byte_step;
    t_vctl   vctl;
    t_vres   vres;
    t_result res;

    // The held item is processed when the result register can take a result.
    assign take_item = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || take_item;
    assign byte_step = take_item && (r_op == OP_BYTE);

    assign vctl.clear = take_item && (r_op == OP_BEGIN);
    assign vctl.step  = byte_step && walking;

    qard_varint u_varint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (vctl),
        .i_byte  (r_data_byte),
        .o_res   (vres)
    );

    qard_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_begin       (vctl.clear),
        .i_largest     (r_largest),
        .i_range_count (r_range_count),
        .i_byte_step   (byte_step),
        .i_last        (r_last_byte),
        .i_vres        (vres),
        .o_walking     (walking),
        .o_res         (res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op          <= i_op;
            r_largest     <= i_largest;
            r_range_count <= i_range_count;
            r_data_byte   <= i_data_byte;
            r_last_byte   <= i_last_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take_item && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_item && res.emit) begin
            r_range_low  <= res.low;
            r_range_high <= res.high;
            r_status     <= res.status;
            r_last_range <= res.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_range_low  = r_range_low;
    assign o_range_high = r_range_high;
    assign o_status     = r_status;
    assign o_last_range = r_last_range;

`ifndef SYNTHESIS
    // An error result carries no range.
    a_enc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ENC)) |-> ((o_range_low == '0) && (o_range_high == '0)))
        else $error("encoding error result carries a range");

    // Every error or truncation result closes the section.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> o_last_range)
        else $error("error result not marked as last");

    // A decoded range is never inverted.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_range_low <= o_range_high))
        else $error("range low above range high");

    // A result appears only after an item was processed.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid)) |-> $past(take_item))
        else $error("result without a processed item");
`endif

endmodule

`default_nettype wire
